[design/scsm_pkg.sv]
// Shared types and constants for the segmented circular sliding-max block.
// No dependencies; used by the core and its interfaces' users.
package scsm_pkg;

    // Configuration port layout
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_R_W    = 6;
    localparam int CFG_K_W    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN          = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER_SEGMENT = 1'd1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_FILL
    } state_t;

endpackage

[design/scsm_sample_if.sv]
// Input channel: one series sample and its end-of-series flag per item.
// Standalone; no package dependency.
interface scsm_sample_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          series_end;

    modport source (output valid, output sample, output series_end, input ready);
    modport sink   (input valid, input sample, input series_end, output ready);
endinterface

[design/scsm_result_if.sv]
// Output channel: one window maximum and its last-of-run flag per item.
// Standalone; no package dependency.
interface scsm_result_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic                          run_last;

    modport source (output valid, output window_max, output run_last, input ready);
    modport sink   (input valid, input window_max, input run_last, output ready);
endinterface

[design/segmented_circular_sliding_max_core.sv]
// Top level of the segmented circular sliding-max block.
// Uses scsm_pkg, scsm_sample_if, scsm_result_if and scsm_ram.
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+-------------------------------
//  samples   | in  | valid/ready     | sample, series_end
//  results   | out | valid/ready     | window_max, run_last
//  cfg       | in  | cfg_we (no wait)| cfg_index, cfg_wdata
//
// An item that completes no window leaves the sequencer idle; one that completes
// a window has it scanned and its result emitted; one that ends a segment has
// r windows scanned and emitted in turn: one shared compare unit walks the r
// samples of each window, one RAM read per cycle. A short final segment of n
// samples gives n results. Output stalls hold the sequencer in its emit/fill state.
// Reset is asynchronous; the sample RAMs need no clearing.
module segmented_circular_sliding_max_core #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    scsm_sample_if.sink                      samples,
    scsm_result_if.source                    results
);

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RW    = $clog2(MAX_WINDOW + 1);
    localparam int EW    = RW + 1;
    localparam int KW    = scsm_pkg::CFG_K_W;
    localparam int SEG_W = scsm_pkg::CFG_K_W + RW;
    localparam int SB    = SAMPLE_BITS;

    // Control state
    scsm_pkg::state_t              state_reg, state_next;
    logic [RW-1:0]                 r_reg, r_next;
    logic [scsm_pkg::CFG_K_W-1:0]  k_reg, k_next;
    logic [SEG_W-1:0]              seglen_reg, seglen_next;
    logic [SEG_W-1:0]              seg_pos_reg, seg_pos_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [AW-1:0]                 base_reg, base_next;
    logic [RW-1:0]                 t_reg, t_next;
    logic [RW-1:0]                 n_reg, n_next;
    logic [RW-1:0]                 j_reg, j_next;
    logic [EW-1:0]                 e_reg, e_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic                          rd_head_reg, rd_head_next;
    logic                          rd_first_reg, rd_first_next;
    logic                          rd_end_reg, rd_end_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload
    logic signed [SB-1:0]          running_max_reg, running_max_next;
    logic signed [SB-1:0]          acc_reg, acc_next;
    logic signed [SB-1:0]          out_max_reg, out_max_next;
    logic                          out_last_reg, out_last_next;

    // Handshake and accept decode
    logic                          accept;
    logic                          out_free;
    logic                          out_load;
    logic [SEG_W-1:0]              count;
    logic                          short_run;
    logic                          run_fill;
    logic                          run_full;
    logic                          run_one;
    logic                          last_result;

    // Config decode
    logic [scsm_pkg::CFG_R_W-1:0]  cfg_wl;
    logic [RW-1:0]                 cfg_r_eff;
    logic [scsm_pkg::CFG_K_W-1:0]  cfg_k_eff;

    // RAM ports
    logic                          issue;
    logic [EW:0]                   store_sum;
    logic [AW-1:0]                 store_raddr;
    logic [AW-1:0]                 head_raddr;
    logic [SB-1:0]                 store_rdata;
    logic [SB-1:0]                 head_rdata;
    logic signed [SB-1:0]          rd_val;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign samples.ready      = (state_reg == scsm_pkg::ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.window_max = out_max_reg;
    assign results.run_last   = out_last_reg;

    // What the accepted sample completes
    assign count       = seg_pos_reg + SEG_W'(1);
    assign short_run   = count < SEG_W'(r_reg);
    assign run_fill    = samples.series_end && short_run;
    assign run_full    = !run_fill && (samples.series_end || count >= seglen_reg);
    assign run_one     = !run_fill && !run_full && !short_run;
    assign last_result = (t_reg == n_reg - RW'(1));

    // Effective register values from the write data
    always_comb
    begin
        cfg_wl = cfg_wdata[scsm_pkg::CFG_R_W-1:0];
        if (cfg_wl == '0)
        begin
            cfg_r_eff = RW'(1);
        end
        else if (int'(cfg_wl) > MAX_WINDOW)
        begin
            cfg_r_eff = RW'(MAX_WINDOW);
        end
        else
        begin
            cfg_r_eff = RW'(cfg_wl);
        end
        cfg_k_eff = (cfg_wdata[scsm_pkg::CFG_K_W-1:0] == '0)
                    ? KW'(1) : cfg_wdata[scsm_pkg::CFG_K_W-1:0];
    end

    // Scan addressing: element e of the window is store[base+e] below r, head[e-r] from r up
    assign issue       = (state_reg == scsm_pkg::ST_SCAN) && (j_reg < r_reg);
    always_comb
    begin
        store_sum = (EW+1)'(base_reg) + (EW+1)'(e_reg);
        if (store_sum >= (EW+1)'(MAX_WINDOW))
        begin
            store_sum = store_sum - (EW+1)'(MAX_WINDOW);
        end
        store_raddr = AW'(store_sum);
        head_raddr  = (e_reg >= EW'(r_reg)) ? AW'(e_reg - EW'(r_reg)) : '0;
    end

    scsm_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (samples.sample),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    scsm_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WINDOW)
    ) u_head (
        .clk   (clk),
        .we    (accept && short_run),
        .waddr (seg_pos_reg[AW-1:0]),
        .wdata (samples.sample),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    assign rd_val = rd_head_reg ? $signed(head_rdata) : $signed(store_rdata);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scsm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (run_fill)
                    begin
                        state_next = scsm_pkg::ST_FILL;
                    end
                    else if (run_full || run_one)
                    begin
                        state_next = scsm_pkg::ST_SCAN;
                    end
                end
            end
            scsm_pkg::ST_SCAN:
            begin
                if (rd_vld_reg && rd_end_reg)
                begin
                    state_next = scsm_pkg::ST_EMIT;
                end
            end
            scsm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_result ? scsm_pkg::ST_IDLE : scsm_pkg::ST_SCAN;
                end
            end
            scsm_pkg::ST_FILL:
            begin
                if (out_free && last_result)
                begin
                    state_next = scsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration, segment tracking and write pointer
    always_comb
    begin
        r_next           = r_reg;
        k_next           = k_reg;
        seglen_next      = seglen_reg;
        seg_pos_next     = seg_pos_reg;
        wp_next          = wp_reg;
        base_next        = base_reg;
        running_max_next = running_max_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scsm_pkg::CFG_WINDOW_LEN:
                begin
                    r_next       = cfg_r_eff;
                    seglen_next  = SEG_W'(cfg_r_eff) * SEG_W'(k_reg);
                    seg_pos_next = '0;
                end
                scsm_pkg::CFG_WINDOWS_PER_SEGMENT:
                begin
                    k_next       = cfg_k_eff;
                    seglen_next  = SEG_W'(r_reg) * SEG_W'(cfg_k_eff);
                    seg_pos_next = '0;
                end
                default:
                begin
                    r_next = r_reg;
                end
            endcase
        end
        else if (accept)
        begin
            wp_next = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
            // oldest sample of the window that ends at this one
            if ((AW+1)'(wp_reg) >= (AW+1)'(r_reg - RW'(1)))
            begin
                base_next = AW'((AW+1)'(wp_reg) - (AW+1)'(r_reg - RW'(1)));
            end
            else
            begin
                base_next = AW'((AW+1)'(wp_reg) + (AW+1)'(MAX_WINDOW)
                                - (AW+1)'(r_reg - RW'(1)));
            end
            if ((seg_pos_reg == '0) || (samples.sample > running_max_reg))
            begin
                running_max_next = samples.sample;
            end
            seg_pos_next = (samples.series_end || count >= seglen_reg) ? '0 : count;
        end
    end

    // Sequencer counters, compare unit and output register
    always_comb
    begin
        t_next         = t_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        out_load       = 1'b0;
        out_max_next   = out_max_reg;
        out_last_next  = out_last_reg;
        rd_vld_next    = issue;
        rd_head_next   = e_reg >= EW'(r_reg);
        rd_first_next  = (j_reg == '0);
        rd_end_next    = (j_reg == r_reg - RW'(1));

        case (state_reg)
            scsm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    t_next = '0;
                    j_next = '0;
                    e_next = '0;
                    if (run_fill)
                    begin
                        n_next = RW'(count);
                    end
                    else if (run_full)
                    begin
                        n_next = r_reg;
                    end
                    else
                    begin
                        n_next = RW'(1);
                    end
                end
            end
            scsm_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    j_next = j_reg + RW'(1);
                    e_next = e_reg + EW'(1);
                end
                // shared compare unit
                if (rd_vld_reg && (rd_first_reg || (rd_val > acc_reg)))
                begin
                    acc_next = rd_val;
                end
            end
            scsm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_max_next  = acc_reg;
                    out_last_next = last_result;
                    t_next        = t_reg + RW'(1);
                    j_next        = '0;
                    e_next        = EW'(t_reg) + EW'(1);
                end
            end
            scsm_pkg::ST_FILL:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_max_next  = running_max_reg;
                    out_last_next = last_result;
                    t_next        = t_reg + RW'(1);
                end
            end
            default:
            begin
                t_next = '0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scsm_pkg::ST_IDLE;
            r_reg         <= RW'(1);
            k_reg         <= KW'(1);
            seglen_reg    <= SEG_W'(1);
            seg_pos_reg   <= '0;
            wp_reg        <= '0;
            base_reg      <= '0;
            t_reg         <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            e_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_head_reg   <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            k_reg         <= k_next;
            seglen_reg    <= seglen_next;
            seg_pos_reg   <= seg_pos_next;
            wp_reg        <= wp_next;
            base_reg      <= base_next;
            t_reg         <= t_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            e_reg         <= e_next;
            rd_vld_reg    <= rd_vld_next;
            rd_head_reg   <= rd_head_next;
            rd_first_reg  <= rd_first_next;
            rd_end_reg    <= rd_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        running_max_reg <= running_max_next;
        acc_reg         <= acc_next;
        out_max_reg     <= out_max_next;
        out_last_reg    <= out_last_next;
    end

`ifndef SYNTHESIS
    // read data only comes back while a window is being scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == scsm_pkg::ST_SCAN))
        else $error("scan read data outside of scan");

    // the result counter never passes the run length
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == scsm_pkg::ST_EMIT) || (state_reg == scsm_pkg::ST_FILL))
        |-> (t_reg < n_reg))
        else $error("result index beyond run length");

    // a short final segment is shorter than one window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scsm_pkg::ST_FILL) |-> ((n_reg != '0) && (n_reg < r_reg)))
        else $error("fill run length out of range");

    // the end of the series always restarts the segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.series_end) |=> (seg_pos_reg == '0))
        else $error("segment position not cleared at series end");

    // a new item is taken only after the last result of the previous one is queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_reg == 1'b0 && out_last_next) |=>
        (state_reg == scsm_pkg::ST_IDLE))
        else $error("sequencer not idle after last result");
`endif

endmodule

[design/scsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scsm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
